// File: hdl/wide_string_to_integer_parser_defines.svh
// assertion macros for the string to integer parser
`ifndef WIDE_STRING_TO_INTEGER_PARSER_DEFINES_SVH
`define WIDE_STRING_TO_INTEGER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WSIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define WSIP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSIP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSIP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/wsip_pkg.sv
package wsip_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CU_WIDTH    = 16;
    localparam int BASE_WIDTH  = 8;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LC  = 8'h61;
    localparam logic [7:0] CH_F_LC  = 8'h66;
    localparam logic [7:0] CH_A_UC  = 8'h41;
    localparam logic [7:0] CH_Z_UC  = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [BASE_WIDTH-1:0] BASE_DETECT = 8'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_2      = 8'd2;
    localparam logic [BASE_WIDTH-1:0] BASE_8      = 8'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_10     = 8'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_16     = 8'd16;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_PREFIX = 2'd1,
        PH_DIGITS = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [CU_WIDTH-1:0]   code_unit;
        logic [BASE_WIDTH-1:0] req_base;
        logic                  first_char;
        logic                  last_char;
        logic                  empty_string;
    } t_item;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] parsed_value;
        logic                 parse_status;
    } t_result;

endpackage

// File: hdl/wide_string_to_integer_parser.sv
// a word passes the input register, the combinational parse core and then the result register
// throughput: one word per cycle unless stalled, set by the input and result registers
// a stalled result register holds a full input register, which then holds o_ready low
// reset: synchronous, active low; clears both valid flags and the parse state
`include "wide_string_to_integer_parser_defines.svh"
module wide_string_to_integer_parser
    import wsip_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [CU_WIDTH-1:0]    i_code_unit,
    input  logic [BASE_WIDTH-1:0]  i_req_base,
    input  logic                   i_first_char,
    input  logic                   i_last_char,
    input  logic                   i_empty_string,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_WIDTH-1:0]   o_parsed_value,
    output logic                   o_parse_status
);

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    fire;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.code_unit    = i_code_unit;
    assign in_item.req_base     = i_req_base;
    assign in_item.first_char   = i_first_char;
    assign in_item.last_char    = i_last_char;
    assign in_item.empty_string = i_empty_string;

    assign fire = stage_valid && advance;

    wsip_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    wsip_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsip_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire && res_valid),
        .i_res     (res),
        .i_ready   (i_ready),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_res     (out_res)
    );

    assign o_parsed_value = out_res.parsed_value;
    assign o_parse_status = out_res.parse_status;

    // an empty string word always comes out as an invalid zero
    `WSIP_ASSERT_NXT(a_empty_invalid, i_clk, i_rst_n,
        fire && stage_item.empty_string,
        o_valid && o_parse_status == STATUS_INVALID && o_parsed_value == '0)
    // invalid status never carries a value
    `WSIP_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n,
        o_valid && o_parse_status == STATUS_INVALID, o_parsed_value == '0)
    // a held word is never dropped while the result side stalls
    `WSIP_ASSERT_NXT(a_hold_word, i_clk, i_rst_n,
        stage_valid && !advance, stage_valid && $stable(stage_item))
    // with the result register stalled, ready may only show an empty input register
    `WSIP_ASSERT_IMP(a_ready_stall, i_clk, i_rst_n,
        o_ready && o_valid && !i_ready, !stage_valid)

endmodule

// File: hdl/wsip_in_stage.sv
module wsip_in_stage
    import wsip_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // the held word leaves whenever the result side can move
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/wsip_parse_core.sv
module wsip_parse_core
    import wsip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase                 r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [BASE_WIDTH-1:0]  r_base, n_base;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;

    function automatic logic base_ok(input logic [BASE_WIDTH-1:0] b);
        return (b == BASE_2) || (b == BASE_8) || (b == BASE_10) || (b == BASE_16);
    endfunction

    always_comb begin
        t_phase                 ph;
        logic                   neg;
        logic [BASE_WIDTH-1:0]  base;
        logic [VALUE_WIDTH-1:0] acc;
        logic [VALUE_WIDTH-1:0] acc_mul;
        logic [VALUE_WIDTH-1:0] val;
        logic [7:0]             c;
        logic [3:0]             d;
        logic                   is_digit;
        logic                   done;

        ph       = r_phase;
        neg      = r_neg;
        base     = r_base;
        acc      = r_acc;
        acc_mul  = '0;
        val      = '0;
        d        = '0;
        is_digit = 1'b0;
        done     = 1'b0;

        if (i_item.first_char) begin
            ph   = PH_SIGN;
            neg  = 1'b0;
            base = i_item.req_base;
            acc  = '0;
        end

        c = i_item.code_unit[7:0];
        if (c >= CH_A_UC && c <= CH_Z_UC) begin
            c = 8'(c + CASE_OFS);
        end

        if (ph == PH_SIGN) begin
            ph = PH_PREFIX;
            if (c == CH_MINUS) begin
                neg  = 1'b1;
                done = 1'b1;
            end else if (c == CH_PLUS) begin
                done = 1'b1;
            end
        end

        if (!done && ph == PH_PREFIX) begin
            ph = PH_DIGITS;
            if (base == BASE_DETECT) begin
                done = 1'b1;
                if (c == CH_X) begin
                    base = BASE_16;
                end else if (c == CH_O) begin
                    base = BASE_8;
                end else if (c == CH_B) begin
                    base = BASE_2;
                end else begin
                    base = BASE_10;
                    done = 1'b0;
                end
            end
        end

        if (c >= CH_0 && c <= CH_9) begin
            d        = 4'(c - CH_0);
            is_digit = 1'b1;
        end else if (c >= CH_A_LC && c <= CH_F_LC) begin
            d        = 4'(c - CH_A_LC + BASE_10);
            is_digit = 1'b1;
        end

        // only bases 2, 8, 10 and 16 are used, so the multiply is shifts and one add
        case (base)
            BASE_2:  acc_mul = acc << 1;
            BASE_8:  acc_mul = acc << 3;
            BASE_16: acc_mul = acc << 4;
            default: acc_mul = (acc << 3) + (acc << 1);
        endcase

        if (!done && ph == PH_DIGITS) begin
            if (!base_ok(base) || !is_digit || ({4'd0, d} >= base)) begin
                ph = PH_STOP;
            end else begin
                acc = acc_mul + VALUE_WIDTH'(d);
            end
        end

        val = neg ? -acc : acc;

        o_res_valid        = i_item.empty_string || i_item.last_char;
        o_res.parsed_value = '0;
        o_res.parse_status = STATUS_INVALID;
        if (!i_item.empty_string && base_ok(base)) begin
            o_res.parsed_value = OUT_WIDTH'(val);
            o_res.parse_status = STATUS_OK;
        end

        if (o_res_valid) begin
            n_phase = PH_SIGN;
            n_neg   = 1'b0;
            n_base  = BASE_DETECT;
            n_acc   = '0;
        end else begin
            n_phase = ph;
            n_neg   = neg;
            n_base  = base;
            n_acc   = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIGN;
            r_neg   <= 1'b0;
            r_base  <= BASE_DETECT;
            r_acc   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
        end
    end

endmodule

// File: hdl/wsip_out_stage.sv
module wsip_out_stage
    import wsip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_res <= i_res;
        end
    end

endmodule
